// File: design/edf_ready_queue_with_release_top_defines.svh
`ifndef EDF_READY_QUEUE_WITH_RELEASE_TOP_DEFINES_SVH
`define EDF_READY_QUEUE_WITH_RELEASE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet while rst_n is low
`define EDFQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, quiet while rst_n is low
`define EDFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/edfq_pkg.sv
package edfq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TIME_W      = 32;
    localparam int ID_W        = 8;
    localparam int OP_W        = 2;
    localparam int ST_W        = 2;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef logic [TIME_W-1:0] time_t;
    typedef logic [ID_W-1:0]   id_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_INSERT = 2'd1,
        OP_SELECT = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DL,
        S_INS_SCAN,
        S_INS_PUT,
        S_SEL_SCAN,
        S_RESULT
    } state_t;

    typedef struct packed {
        id_t   id;
        time_t rel;
        time_t dline;
    } entry_t;

    typedef struct packed {
        logic   wr_en;
        addr_t  wr_addr;
        entry_t wr_data;
        logic   rd_en;
        addr_t  rd_addr;
    } mem_req_t;

    function automatic time_t sat_add(time_t a, time_t b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

// File: design/edfq_cmd_if.sv
interface edfq_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [edfq_pkg::OP_W-1:0]    op;
    logic [edfq_pkg::ID_W-1:0]    task_id;
    logic [edfq_pkg::TIME_W-1:0]  start_offset;
    logic [edfq_pkg::TIME_W-1:0]  deadline_offset;

    modport source (output valid, op, task_id, start_offset, deadline_offset, input ready);
    modport sink   (input valid, op, task_id, start_offset, deadline_offset, output ready);
endinterface

// File: design/edfq_res_if.sv
interface edfq_res_if;
    logic                         valid;
    logic                         ready;
    logic [edfq_pkg::ST_W-1:0]    status;
    logic [edfq_pkg::ID_W-1:0]    chosen_id;
    logic [edfq_pkg::TIME_W-1:0]  chosen_deadline;
    logic [edfq_pkg::TIME_W-1:0]  now_ms;

    modport source (output valid, status, chosen_id, chosen_deadline, now_ms, input ready);
    modport sink   (input valid, status, chosen_id, chosen_deadline, now_ms, output ready);
endinterface

// File: design/edfq_mem.sv
module edfq_mem (
    input  logic               clk,
    input  edfq_pkg::mem_req_t req,
    output edfq_pkg::entry_t   rd_data
);

    edfq_pkg::entry_t mem [edfq_pkg::QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// File: design/edfq_ctrl.sv
module edfq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    edfq_cmd_if.sink           cmd,
    edfq_res_if.source         res,
    output edfq_pkg::mem_req_t mem_req,
    input  edfq_pkg::entry_t   rd_data
);

    edfq_pkg::state_t  state_reg, state_next;
    edfq_pkg::time_t   now_reg, now_next;
    edfq_pkg::cnt_t    count_reg, count_next;
    logic              found_reg, found_next;
    logic              out_valid_reg, out_valid_next;

    edfq_pkg::addr_t   idx_reg, idx_next;
    edfq_pkg::entry_t  new_reg, new_next;
    edfq_pkg::time_t   dloff_reg, dloff_next;
    edfq_pkg::status_t status_reg, status_next;
    edfq_pkg::id_t     pick_id_reg, pick_id_next;
    edfq_pkg::time_t   pick_dl_reg, pick_dl_next;
    edfq_pkg::status_t out_status_reg, out_status_next;
    edfq_pkg::id_t     out_id_reg, out_id_next;
    edfq_pkg::time_t   out_dl_reg, out_dl_next;
    edfq_pkg::time_t   out_now_reg, out_now_next;

    logic              hit;
    logic              last;

    assign hit  = rd_data.rel <= now_reg;
    assign last = (edfq_pkg::CNT_W'(idx_reg) + edfq_pkg::CNT_W'(1)) == count_reg;

    always_comb
    begin
        state_next      = state_reg;
        now_next        = now_reg;
        count_next      = count_reg;
        found_next      = found_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        idx_next        = idx_reg;
        new_next        = new_reg;
        dloff_next      = dloff_reg;
        status_next     = status_reg;
        pick_id_next    = pick_id_reg;
        pick_dl_next    = pick_dl_reg;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_dl_next     = out_dl_reg;
        out_now_next    = out_now_reg;
        mem_req         = '0;
        cmd.ready       = 1'b0;

        case (state_reg)
            edfq_pkg::S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    pick_id_next = '0;
                    pick_dl_next = '0;
                    status_next  = edfq_pkg::ST_DONE;
                    state_next   = edfq_pkg::S_RESULT;
                    case (edfq_pkg::op_t'(cmd.op))
                        edfq_pkg::OP_TICK:
                        begin
                            if (now_reg != {edfq_pkg::TIME_W{1'b1}})
                            begin
                                now_next = now_reg + edfq_pkg::TIME_W'(1);
                            end
                        end
                        edfq_pkg::OP_INSERT:
                        begin
                            if (count_reg == edfq_pkg::CNT_W'(edfq_pkg::QUEUE_DEPTH))
                            begin
                                status_next = edfq_pkg::ST_FULL;
                            end
                            else
                            begin
                                new_next.id  = cmd.task_id;
                                new_next.rel = edfq_pkg::sat_add(now_reg, cmd.start_offset);
                                dloff_next   = cmd.deadline_offset;
                                state_next   = edfq_pkg::S_DL;
                            end
                        end
                        edfq_pkg::OP_SELECT:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = edfq_pkg::ST_NONE;
                            end
                            else
                            begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = '0;
                                idx_next        = '0;
                                found_next      = 1'b0;
                                state_next      = edfq_pkg::S_SEL_SCAN;
                            end
                        end
                        default:
                        begin
                            status_next = edfq_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            edfq_pkg::S_DL:
            begin
                new_next.dline = edfq_pkg::sat_add(new_reg.rel, dloff_reg);
                if (count_reg == '0)
                begin
                    idx_next   = '0;
                    state_next = edfq_pkg::S_INS_PUT;
                end
                else
                begin
                    // scan from the tail towards the head
                    idx_next        = edfq_pkg::ADDR_W'(count_reg - edfq_pkg::CNT_W'(1));
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = idx_next;
                    state_next      = edfq_pkg::S_INS_SCAN;
                end
            end

            edfq_pkg::S_INS_SCAN:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_reg + edfq_pkg::ADDR_W'(1);
                if (rd_data.dline >= new_reg.dline)
                begin
                    // later or equal deadline moves up one place
                    mem_req.wr_data = rd_data;
                    if (idx_reg == '0)
                    begin
                        state_next = edfq_pkg::S_INS_PUT;
                    end
                    else
                    begin
                        idx_next        = idx_reg - edfq_pkg::ADDR_W'(1);
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = idx_next;
                    end
                end
                else
                begin
                    mem_req.wr_data = new_reg;
                    count_next      = count_reg + edfq_pkg::CNT_W'(1);
                    state_next      = edfq_pkg::S_RESULT;
                end
            end

            edfq_pkg::S_INS_PUT:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_reg;
                mem_req.wr_data = new_reg;
                count_next      = count_reg + edfq_pkg::CNT_W'(1);
                state_next      = edfq_pkg::S_RESULT;
            end

            edfq_pkg::S_SEL_SCAN:
            begin
                if (found_reg)
                begin
                    // close the gap left by the chosen entry
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = idx_reg - edfq_pkg::ADDR_W'(1);
                    mem_req.wr_data = rd_data;
                end
                else if (hit)
                begin
                    found_next   = 1'b1;
                    pick_id_next = rd_data.id;
                    pick_dl_next = rd_data.dline;
                end
                if (last)
                begin
                    if (found_reg || hit)
                    begin
                        count_next  = count_reg - edfq_pkg::CNT_W'(1);
                        status_next = edfq_pkg::ST_DONE;
                    end
                    else
                    begin
                        status_next = edfq_pkg::ST_NONE;
                    end
                    state_next = edfq_pkg::S_RESULT;
                end
                else
                begin
                    idx_next        = idx_reg + edfq_pkg::ADDR_W'(1);
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = idx_next;
                end
            end

            edfq_pkg::S_RESULT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_id_next     = pick_id_reg;
                    out_dl_next     = pick_dl_reg;
                    out_now_next    = now_reg;
                    state_next      = edfq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = edfq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= edfq_pkg::S_IDLE;
            now_reg       <= '0;
            count_reg     <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            count_reg     <= count_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        new_reg        <= new_next;
        dloff_reg      <= dloff_next;
        status_reg     <= status_next;
        pick_id_reg    <= pick_id_next;
        pick_dl_reg    <= pick_dl_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_dl_reg     <= out_dl_next;
        out_now_reg    <= out_now_next;
    end

    assign res.valid           = out_valid_reg;
    assign res.status          = out_status_reg;
    assign res.chosen_id       = out_id_reg;
    assign res.chosen_deadline = out_dl_reg;
    assign res.now_ms          = out_now_reg;

endmodule

// File: design/edf_ready_queue_with_release_top.sv
// Earliest-deadline-first ready queue of 16 tasks with a saturating millisecond clock.
// Entries live in one synchronous memory kept sorted by deadline; the controller walks
// it one entry a cycle through the single read port, moving entries up on an insert and
// down on a select. A tick, a no-op, an insert into a full queue or a select on an empty
// queue goes from idle straight to the result state; an insert forms the deadline, then
// moves up each stored entry whose deadline is equal or later and writes the new entry in
// the gap; a select reads every entry from the head. One item is worked on at a time,
// and the next is taken while the previous result still waits in the output register.
module edf_ready_queue_with_release_top (
    input logic        clk,
    input logic        rst_n,
    edfq_cmd_if.sink   cmd,
    edfq_res_if.source res
);

    edfq_pkg::mem_req_t mem_req;
    edfq_pkg::entry_t   rd_data;

    edfq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .res     (res),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    edfq_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

endmodule

// File: design/edfq_checker.sv
`include "edf_ready_queue_with_release_top_defines.svh"

module edfq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_ready,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [edfq_pkg::ST_W-1:0]     res_status,
    input logic [edfq_pkg::ID_W-1:0]     res_chosen_id,
    input logic [edfq_pkg::TIME_W-1:0]   res_chosen_deadline,
    input logic [edfq_pkg::TIME_W-1:0]   res_now_ms
);

    // a waiting result keeps its payload
    `EDFQ_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
        res_valid && $stable(res_status) && $stable(res_chosen_id)
        && $stable(res_chosen_deadline) && $stable(res_now_ms),
        "result changed while stalled")

    // only a successful select names a task
    `EDFQ_ASSERT_NOW(a_fail_zero, res_valid && res_status != edfq_pkg::ST_DONE,
        res_chosen_id == '0 && res_chosen_deadline == '0,
        "failed item carries a task")

    // one item at a time: busy right after taking an item
    `EDFQ_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready,
        "item taken while busy")

endmodule

bind edf_ready_queue_with_release_top edfq_checker u_edfq_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd_valid           (cmd.valid),
    .cmd_ready           (cmd.ready),
    .res_valid           (res.valid),
    .res_ready           (res.ready),
    .res_status          (res.status),
    .res_chosen_id       (res.chosen_id),
    .res_chosen_deadline (res.chosen_deadline),
    .res_now_ms          (res.now_ms)
);
